[rtl/core/rbs_pkg.sv]
package rbs_pkg;

  localparam int CoordW  = 48;
  localparam int DirW    = 27;
  localparam int DiffW   = CoordW + 1;
  localparam int QuoW    = 47;
  localparam int RemW    = DirW;
  localparam int TolW    = 24;
  localparam int TW      = QuoW + 1;
  localparam int NumAxes = 3;
  localparam int SatShift = QuoW - 24;
  localparam int FracBits = 24;
  localparam int ParallelEpsilon = 168;

  localparam logic [QuoW-1:0] T_INF = {QuoW{1'b1}};
  localparam logic signed [DirW-1:0] EPS_POS = DirW'(ParallelEpsilon);
  localparam logic signed [DirW-1:0] EPS_NEG = -EPS_POS;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X   = 3'd0,
    REG_BOX_MIN_Y   = 3'd1,
    REG_BOX_MIN_Z   = 3'd2,
    REG_BOX_MAX_X   = 3'd3,
    REG_BOX_MAX_Y   = 3'd4,
    REG_BOX_MAX_Z   = 3'd5,
    REG_CLOSE_TOL   = 3'd6,
    REG_DEPTH_TOL   = 3'd7
  } cfg_reg_e;

  // One long division in flight: partial remainder, dividend bits still to
  // shift in, and the quotient bits found so far.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] pend;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [DirW-1:0] ad;
    logic            par;
    logic            pmiss;
    logic            far_neg;
    logic            near_neg;
    logic            sat_far;
    logic            sat_near;
    div_lane_t       far;
    div_lane_t       near;
  } div_axis_t;

  typedef div_axis_t [NumAxes-1:0] div_bundle_t;

  typedef struct packed {
    logic            par;
    logic            pmiss;
    logic [TolW-1:0] tol;
    logic [TW-1:0]   tfar;
    logic [TW-1:0]   tnear;
  } slab_axis_t;

  typedef struct packed {
    logic                       ok;
    logic [TW-1:0]              tmin;
    logic [TW-1:0]              tmax;
    slab_axis_t [NumAxes-1:0]   ax;
  } slab_t;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DirW-1:0] ad);
    logic [RemW:0] s;
    div_lane_t     r;
    s = {l.rem, l.pend[QuoW-1]};
    r.pend = {l.pend[QuoW-2:0], 1'b0};
    if (s >= {1'b0, ad}) begin
      r.rem = RemW'(s - {1'b0, ad});
      r.quo = {l.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = s[RemW-1:0];
      r.quo = {l.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/core/rbs_ray_if.sv]
interface rbs_ray_if;
  import rbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] origin_x;
  logic [CoordW-1:0] origin_y;
  logic [CoordW-1:0] origin_z;
  logic [DirW-1:0]   direction_x;
  logic [DirW-1:0]   direction_y;
  logic [DirW-1:0]   direction_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, output ready);
endinterface

[rtl/core/rbs_hit_if.sv]
interface rbs_hit_if;
  import rbs_pkg::*;
  logic            valid;
  logic            ready;
  logic            hit;
  logic [QuoW-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

[rtl/core/rbs_prep.sv]
module rbs_prep (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  in_valid,
  input  logic [rbs_pkg::NumAxes-1:0][rbs_pkg::CoordW-1:0] origin,
  input  logic [rbs_pkg::NumAxes-1:0][rbs_pkg::DirW-1:0]   dir,
  input  logic [rbs_pkg::NumAxes-1:0][rbs_pkg::CoordW-1:0] lo,
  input  logic [rbs_pkg::NumAxes-1:0][rbs_pkg::CoordW-1:0] hi,
  output logic                                  out_valid,
  output rbs_pkg::div_bundle_t                  out_data
);
  import rbs_pkg::*;

  logic                                 a_valid;
  logic [NumAxes-1:0][DiffW-1:0]        a_dlo, a_dhi, a_dlo_next, a_dhi_next;
  logic [NumAxes-1:0][DirW-1:0]         a_ad, a_ad_next;
  logic [NumAxes-1:0]                   a_dneg, a_par, a_pmiss;
  logic [NumAxes-1:0]                   a_par_next, a_pmiss_next;
  div_bundle_t                          out_data_next;

  // First stage: offsets of both bounds from the origin and the divisor magnitude.
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      a_dlo_next[i] = {lo[i][CoordW-1], lo[i]} - {origin[i][CoordW-1], origin[i]};
      a_dhi_next[i] = {hi[i][CoordW-1], hi[i]} - {origin[i][CoordW-1], origin[i]};
      a_ad_next[i]  = dir[i][DirW-1] ? (~dir[i] + 1'b1) : dir[i];
      a_par_next[i] = ($signed(dir[i]) >= EPS_NEG) && ($signed(dir[i]) <= EPS_POS);
      a_pmiss_next[i] = ($signed(a_dlo_next[i]) > 0) || a_dhi_next[i][DiffW-1];
    end
  end

  // Second stage: pick far and near bounds, take magnitudes and set up division.
  always_comb begin
    logic [DiffW-1:0] f, n, af, an;
    for (int i = 0; i < NumAxes; i++) begin
      f  = a_dneg[i] ? a_dlo[i] : a_dhi[i];
      n  = a_dneg[i] ? a_dhi[i] : a_dlo[i];
      af = f[DiffW-1] ? (~f + 1'b1) : f;
      an = n[DiffW-1] ? (~n + 1'b1) : n;
      out_data_next[i].ad       = a_ad[i];
      out_data_next[i].par      = a_par[i];
      out_data_next[i].pmiss    = a_pmiss[i];
      out_data_next[i].far_neg  = f[DiffW-1] ^ a_dneg[i];
      out_data_next[i].near_neg = n[DiffW-1] ^ a_dneg[i];
      out_data_next[i].sat_far  = {1'b0, af} >= {a_ad[i], {SatShift{1'b0}}};
      out_data_next[i].sat_near = {1'b0, an} >= {a_ad[i], {SatShift{1'b0}}};
      out_data_next[i].far.rem  = {1'b0, af[DiffW-1:SatShift]};
      out_data_next[i].far.pend = {af[SatShift-1:0], {FracBits{1'b0}}};
      out_data_next[i].far.quo  = '0;
      out_data_next[i].near.rem  = {1'b0, an[DiffW-1:SatShift]};
      out_data_next[i].near.pend = {an[SatShift-1:0], {FracBits{1'b0}}};
      out_data_next[i].near.quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_dlo   <= a_dlo_next;
      a_dhi   <= a_dhi_next;
      a_ad    <= a_ad_next;
      a_par   <= a_par_next;
      a_pmiss <= a_pmiss_next;
      for (int i = 0; i < NumAxes; i++) a_dneg[i] <= dir[i][DirW-1];
      out_data <= out_data_next;
    end
  end

endmodule

[rtl/core/rbs_div_cell.sv]
module rbs_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  rbs_pkg::div_bundle_t in_data,
  output logic                 out_valid,
  output rbs_pkg::div_bundle_t out_data
);
  import rbs_pkg::*;

  div_bundle_t out_data_next;

  // One quotient bit for each of the six divisions.
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      out_data_next[i]      = in_data[i];
      out_data_next[i].far  = div_step(in_data[i].far, in_data[i].ad);
      out_data_next[i].near = div_step(in_data[i].near, in_data[i].ad);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= out_data_next;
  end

endmodule

[rtl/core/rbs_slab_cell.sv]
module rbs_slab_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           in_valid,
  input  rbs_pkg::slab_t in_data,
  output logic           out_valid,
  output rbs_pkg::slab_t out_data
);
  import rbs_pkg::*;

  slab_t out_data_next;

  // Narrows the interval with the axis at the head of the list, then moves
  // the remaining axes up one place.
  always_comb begin
    logic [TW:0]   max_lim, min_lim;
    logic [TW-1:0] tmax_new;
    logic          upd_max, upd_min;
    slab_axis_t    a;
    a       = in_data.ax[0];
    max_lim = {in_data.tmax[TW-1], in_data.tmax} - {{(TW+1-TolW){1'b0}}, a.tol};
    min_lim = {in_data.tmin[TW-1], in_data.tmin} + {{(TW+1-TolW){1'b0}}, a.tol};
    upd_max = $signed({a.tfar[TW-1], a.tfar}) <= $signed(max_lim);
    upd_min = $signed({a.tnear[TW-1], a.tnear}) >= $signed(min_lim);
    tmax_new = upd_max ? a.tfar : in_data.tmax;
    out_data_next = in_data;
    for (int i = 0; i < NumAxes - 1; i++) out_data_next.ax[i] = in_data.ax[i+1];
    if (in_data.ok) begin
      if (a.par) begin
        out_data_next.ok = !a.pmiss;
      end else if ($signed(a.tfar) < $signed(in_data.tmin)) begin
        out_data_next.ok = 1'b0;
      end else begin
        out_data_next.tmax = tmax_new;
        if (upd_min) begin
          if ($signed(a.tnear) > $signed(tmax_new)) out_data_next.ok = 1'b0;
          else out_data_next.tmin = a.tnear;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= out_data_next;
  end

endmodule

[rtl/core/ray_box_slab_intersection_core.sv]
// Channel   Direction  Contents
// ray       in         origin_x/y/z (Q24.24), direction_x/y/z (Q3.24)
// res       out        hit, distance (Q23.24, all ones on a miss)
// cfg_*     in         write enable, register index, write data
//
// One ray is taken in every cycle unless the chain is held; each ray passes
// through two set-up stages, 47 divider cells (one quotient bit each), a
// sign stage, three slab cells (X, Y, Z) and the output register.
// The cell count is set by the 47-bit quotient of the restoring divider.
// Reset is synchronous; it clears every valid bit, zeroes the box bounds and
// sets both tolerances back to 17.
// While a result waits in the output register the chain still moves as long
// as the last slab cell is empty, so requests are taken until a result
// reaches that cell; from then on the whole chain and the input are held.
module ray_box_slab_intersection_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [rbs_pkg::CoordW-1:0]  cfg_data,
  rbs_ray_if.sink                     ray,
  rbs_hit_if.source                   res
);
  import rbs_pkg::*;

  localparam int SlabCells = NumAxes;

  // Configuration registers.
  logic [NumAxes-1:0][CoordW-1:0] box_lo, box_hi;
  logic [TolW-1:0]                close_tol, depth_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo    <= '0;
      box_hi    <= '0;
      close_tol <= TolW'(17);
      depth_tol <= TolW'(17);
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        REG_CLOSE_TOL: close_tol <= cfg_data[TolW-1:0];
        REG_DEPTH_TOL: depth_tol <= cfg_data[TolW-1:0];
      endcase
    end
  end

  // The whole chain moves together. It may move whenever the output register
  // is free or being emptied, or when the last stage holds no result.
  logic advance;
  logic last_valid;
  assign advance   = res.ready || !res.valid || !last_valid;
  assign ray.ready = advance;

  logic [NumAxes-1:0][CoordW-1:0] origin;
  logic [NumAxes-1:0][DirW-1:0]   dir;
  assign origin = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign dir    = {ray.direction_z, ray.direction_y, ray.direction_x};

  logic        div_valid [QuoW+1];
  div_bundle_t div_data  [QuoW+1];

  rbs_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (ray.valid),
    .origin    (origin),
    .dir       (dir),
    .lo        (box_lo),
    .hi        (box_hi),
    .out_valid (div_valid[0]),
    .out_data  (div_data[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    rbs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (div_valid[k]),
      .in_data   (div_data[k]),
      .out_valid (div_valid[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  // Sign stage: saturation and the sign of each crossing distance. The X slab
  // narrows the interval with no tolerance band.
  logic  slab_valid [SlabCells+1];
  slab_t slab_data  [SlabCells+1];
  slab_t sgn_next;

  always_comb begin
    logic [QuoW-1:0] qf, qn;
    div_axis_t       d;
    sgn_next.ok   = 1'b1;
    sgn_next.tmin = '0;
    sgn_next.tmax = {1'b0, T_INF};
    for (int i = 0; i < NumAxes; i++) begin
      d  = div_data[QuoW][i];
      qf = d.sat_far  ? T_INF : d.far.quo;
      qn = d.sat_near ? T_INF : d.near.quo;
      sgn_next.ax[i].par   = d.par;
      sgn_next.ax[i].pmiss = d.pmiss;
      sgn_next.ax[i].tol   = (i == 0) ? '0 : close_tol;
      sgn_next.ax[i].tfar  = d.far_neg  ? (~{1'b0, qf} + 1'b1) : {1'b0, qf};
      sgn_next.ax[i].tnear = d.near_neg ? (~{1'b0, qn} + 1'b1) : {1'b0, qn};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_valid[0] <= 1'b0;
    end else if (advance) begin
      slab_valid[0] <= div_valid[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) slab_data[0] <= sgn_next;
  end

  for (genvar k = 0; k < SlabCells; k++) begin : g_slab
    rbs_slab_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (slab_valid[k]),
      .in_data   (slab_data[k]),
      .out_valid (slab_valid[k+1]),
      .out_data  (slab_data[k+1])
    );
  end

  assign last_valid = slab_valid[SlabCells];

  // Output register with the shallow-exit test.
  slab_t fin;
  logic  fin_hit;
  assign fin     = slab_data[SlabCells];
  assign fin_hit = fin.ok && !($signed(fin.tmax) < $signed({{(TW-TolW){1'b0}}, depth_tol}));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!res.valid || res.ready) begin
      res.hit      <= fin_hit;
      res.distance <= fin_hit ? fin.tmin[QuoW-1:0] : T_INF;
    end
  end

`ifndef SYNTHESIS
  a_miss_distance: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.distance == T_INF)
    else $error("miss result without saturated distance");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    ray.valid && ray.ready |=> u_prep.a_valid)
    else $error("accepted request did not enter the chain");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(last_valid) && last_valid)
    else $error("last stage changed while the chain was held");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !advance |-> res.valid && last_valid)
    else $error("chain held with room to move");
`endif

endmodule
